### rtl/core/hmm_pkg.sv
// ----------------------------------------------------------------------------
// hmm_pkg: shared constants and tables for the HTTP method matcher
// Holds the method name table, name lengths and token length limits.
// ----------------------------------------------------------------------------
package hmm_pkg;

   localparam int METHOD_COUNT  = 33;
   localparam int MAX_NAME_LEN  = 11;
   localparam int NAME_BITS     = 8 * MAX_NAME_LEN;
   localparam int POS_WIDTH     = 4;
   localparam int CODE_WIDTH    = 6;
   localparam int POS_LIMIT     = 14;
   localparam int MIN_TOKEN_LEN = 3;
   localparam int DEF_MAX_TOKEN_LEN = 13;

   localparam logic [CODE_WIDTH-1:0] CODE_UNKNOWN = '0;

   typedef logic [METHOD_COUNT-1:0] mask_type;
   typedef logic [POS_WIDTH-1:0]    pos_type;
   typedef logic [CODE_WIDTH-1:0]   code_type;

   // Names are right-justified: the last character sits in the low byte.
   localparam logic [NAME_BITS-1:0] METHOD_TEXT [METHOD_COUNT] = '{
      NAME_BITS'("ACL"),        NAME_BITS'("BIND"),       NAME_BITS'("CHECKOUT"),
      NAME_BITS'("CONNECT"),    NAME_BITS'("COPY"),       NAME_BITS'("DELETE"),
      NAME_BITS'("GET"),        NAME_BITS'("HEAD"),       NAME_BITS'("LINK"),
      NAME_BITS'("LOCK"),       NAME_BITS'("M-SEARCH"),   NAME_BITS'("MERGE"),
      NAME_BITS'("MKACTIVITY"), NAME_BITS'("MKCALENDAR"), NAME_BITS'("MKCOL"),
      NAME_BITS'("MOVE"),       NAME_BITS'("NOTIFY"),     NAME_BITS'("OPTIONS"),
      NAME_BITS'("PATCH"),      NAME_BITS'("POST"),       NAME_BITS'("PROPFIND"),
      NAME_BITS'("PROPPATCH"),  NAME_BITS'("PURGE"),      NAME_BITS'("PUT"),
      NAME_BITS'("REBIND"),     NAME_BITS'("REPORT"),     NAME_BITS'("SEARCH"),
      NAME_BITS'("SUBSCRIBE"),  NAME_BITS'("TRACE"),      NAME_BITS'("UNBIND"),
      NAME_BITS'("UNLINK"),     NAME_BITS'("UNLOCK"),     NAME_BITS'("UNSUBSCRIBE")
   };

   localparam pos_type METHOD_LEN [METHOD_COUNT] = '{
      4'd3, 4'd4, 4'd8, 4'd7, 4'd4, 4'd6, 4'd3, 4'd4, 4'd4, 4'd4, 4'd8,
      4'd5, 4'd10, 4'd10, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4, 4'd8, 4'd9,
      4'd5, 4'd3, 4'd6, 4'd6, 4'd6, 4'd9, 4'd5, 4'd6, 4'd6, 4'd6, 4'd11
   };

   // Character of method k at position pos; only meaningful for pos < length.
   function automatic logic [7:0] method_char(input int k, input pos_type pos);
      logic [7:0] ch;
      ch = '0;
      for (int p = 0; p < MAX_NAME_LEN; p++) begin
         if (pos == POS_WIDTH'(p) && p < int'(METHOD_LEN[k])) begin
            ch = METHOD_TEXT[k][8 * (int'(METHOD_LEN[k]) - 1 - p) +: 8];
         end
      end
      return ch;
   endfunction

endpackage

### rtl/core/http_method_matcher_unit.sv
// ----------------------------------------------------------------------------
// http_method_matcher_unit: streaming HTTP request method recognizer
// Matches a byte-serial method token against 33 names, one code per token.
// ----------------------------------------------------------------------------
// Takes one token byte per cycle and, on the byte marked final, returns one
// method code (0 unknown, 1..33 the methods in table order). Matching is exact
// and case-sensitive over the whole token; tokens shorter than 3 bytes or
// longer than MAX_TOKEN_LEN give 0. A byte is registered on entry and its mask
// update and code select run from that register into the result register,
// so the code of a final byte passes both registers before it shows, and the
// sustained rate is one byte per cycle. Only a stalled result with a further
// final byte waiting holds the input side.
module http_method_matcher_unit #(
   parameter int MAX_TOKEN_LEN = hmm_pkg::DEF_MAX_TOKEN_LEN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_token_byte,
   input  logic                       req_is_final,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [hmm_pkg::CODE_WIDTH-1:0] rsp_method_code
);
   import hmm_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_final_ff, in_final_in;
   pos_type    pos_ff,      pos_in;
   mask_type   mask_ff,     mask_in;
   logic       out_valid_ff, out_valid_in;
   code_type   out_code_ff,  out_code_in;

   logic       out_free;
   logic       s1_advance;
   mask_type   next_mask;
   pos_type    token_len;
   code_type   code;

   // Output register is free when empty or being drained this cycle.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_advance = in_valid_ff && (!in_final_ff || out_free);
   assign req_stall  = in_valid_ff && !s1_advance;

   // Clear candidates that disagree with the current byte.
   always_comb begin
      for (int k = 0; k < METHOD_COUNT; k++) begin
         next_mask[k] = mask_ff[k] && (pos_ff < METHOD_LEN[k]) &&
                        (method_char(k, pos_ff) == in_byte_ff);
      end
   end

   // Pick the first surviving name whose length equals the token length.
   assign token_len = pos_ff + 1'b1;
   always_comb begin
      code = CODE_UNKNOWN;
      if (token_len >= POS_WIDTH'(MIN_TOKEN_LEN) &&
          token_len <= POS_WIDTH'(MAX_TOKEN_LEN)) begin
         for (int k = METHOD_COUNT - 1; k >= 0; k--) begin
            if (next_mask[k] && METHOD_LEN[k] == token_len) begin
               code = CODE_WIDTH'(k + 1);
            end
         end
      end
   end

   // Next-state logic for input stage, match state and result register.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_final_in  = in_final_ff;
      pos_in       = pos_ff;
      mask_in      = mask_ff;
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (s1_advance) begin
         in_valid_in = 1'b0;
         if (in_final_ff) begin
            pos_in       = '0;
            mask_in      = '1;
            out_valid_in = 1'b1;
            out_code_in  = code;
         end else begin
            mask_in = next_mask;
            if (pos_ff < POS_WIDTH'(POS_LIMIT)) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
      // Take a new transfer whenever the input stage is empty or advancing.
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_token_byte;
         in_final_in = req_is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         mask_ff      <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      out_code_ff <= out_code_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_method_code = out_code_ff;

   // Position never runs past its saturation point.
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_WIDTH'(POS_LIMIT))
      else $error("byte position above limit");

   // A final byte restarts the match state.
   a_final_restart: assert property (@(posedge clock) disable iff (reset)
      s1_advance && in_final_ff |=> pos_ff == '0 && mask_ff == '1)
      else $error("match state not restarted after final byte");

   // A non-final byte never produces a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !in_final_ff && !(out_valid_ff && !rsp_stall)
      |=> out_valid_ff == $past(out_valid_ff))
      else $error("result produced by non-final byte");

   // Codes stay within the method table.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_code_ff <= CODE_WIDTH'(METHOD_COUNT))
      else $error("method code out of range");

   // Input side only stalls while a final byte waits on a blocked result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_final_ff && out_valid_ff && rsp_stall)
      else $error("unexpected input stall");

endmodule
